### hw/rtl/lcdseq_pkg.sv
// Shared types, codes and the nibble table for the LCD nibble write sequencer.
// No dependencies; every other RTL file imports this package.
package lcdseq_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_POWER_ON_WAIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BYTE_GAP       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SETUP_TICKS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE_HIGH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 3'd4;

  // Configuration reset values
  localparam logic [7:0] RST_POWER_ON_WAIT = 8'd50;
  localparam logic [3:0] RST_BYTE_GAP      = 4'd2;
  localparam logic [7:0] RST_SETUP_TICKS   = 8'd5;
  localparam logic [7:0] RST_ENABLE_HIGH   = 8'd20;
  localparam logic [7:0] RST_HOLD_TICKS    = 8'd20;

  // Command actions
  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_CMD    = 2'd1;
  localparam logic [1:0] ACT_DATA   = 2'd2;
  localparam logic [1:0] ACT_CURSOR = 2'd3;

  // Enable pulse phases for the tick timer
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_ENHI  = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;

  // Nibble index of the final init nibble
  localparam logic [3:0] INIT_LAST_IDX = 4'd11;

  // Fixed init pauses in ms
  localparam logic [7:0] INIT_WAIT_2ND = 8'd5;
  localparam logic [7:0] INIT_WAIT_SHORT = 8'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       row;
    logic [5:0] col;
  } in_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic [7:0] pause_before_ms;
    logic       last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       tmr_load;
    logic [1:0] tmr_phase;
    logic       emit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tmr_zero;
    logic last_nib;
    logic out_free;
  } dp_sts_t;

  // Nibble number idx of command cmd
  function automatic out_t nib_lookup(in_t cmd, logic [3:0] idx, logic [3:0] gap,
                                      logic [7:0] pow);
    out_t       r;
    logic [7:0] b;
    logic [7:0] gap8;
    gap8 = {4'b0000, gap};
    r    = '0;
    b    = cmd.data_byte;
    if (cmd.action == ACT_INIT) begin
      case (idx)
        4'd0:  begin r.nibble = 4'h3; r.pause_before_ms = pow; end
        4'd1:  begin r.nibble = 4'h3; r.pause_before_ms = INIT_WAIT_2ND; end
        4'd2:  begin r.nibble = 4'h3; r.pause_before_ms = INIT_WAIT_SHORT; end
        4'd3:  begin r.nibble = 4'h2; r.pause_before_ms = INIT_WAIT_SHORT; end
        4'd4:  begin r.nibble = 4'h2; r.pause_before_ms = INIT_WAIT_SHORT + gap8; end
        4'd5:  r.nibble = 4'h8;
        4'd6:  begin r.nibble = 4'h0; r.pause_before_ms = gap8; end
        4'd7:  r.nibble = 4'hC;
        4'd8:  begin r.nibble = 4'h0; r.pause_before_ms = gap8; end
        4'd9:  r.nibble = 4'h6;
        4'd10: begin r.nibble = 4'h0; r.pause_before_ms = gap8; end
        4'd11: begin r.nibble = 4'h1; r.last = 1'b1; end
        default: r = '0;
      endcase
    end else begin
      // pick the byte and register select
      case (cmd.action)
        ACT_DATA:   r.reg_select = 1'b1;
        ACT_CURSOR: b = {1'b1, cmd.row, cmd.col};
        default:    r.reg_select = 1'b0;
      endcase
      // high nibble first, then low nibble closes the command
      if (!idx[0]) begin
        r.nibble          = b[7:4];
        r.pause_before_ms = gap8;
      end else begin
        r.nibble = b[3:0];
        r.last   = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/lcdseq_datapath.sv
// Datapath: configuration registers, command register, nibble counter,
// enable pulse tick timer and result register. Depends on lcdseq_pkg.
module lcdseq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcdseq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lcdseq_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  lcdseq_pkg::in_t                   in_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output lcdseq_pkg::out_t                  out_data_o,
  input  lcdseq_pkg::ctrl_cmd_t             cmd_i,
  output lcdseq_pkg::dp_sts_t               sts_o
);
  import lcdseq_pkg::*;

  logic [7:0] pow_q;
  logic [3:0] gap_q;
  logic [7:0] setup_q;
  logic [7:0] enhi_q;
  logic [7:0] hold_q;
  in_t        cmd_q;
  logic [3:0] nib_q, nib_d;
  logic [7:0] tmr_q, tmr_d;
  logic       valid_q, valid_d;
  out_t       res_q;
  out_t       cur;

  // Store configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_q   <= RST_POWER_ON_WAIT;
      gap_q   <= RST_BYTE_GAP;
      setup_q <= RST_SETUP_TICKS;
      enhi_q  <= RST_ENABLE_HIGH;
      hold_q  <= RST_HOLD_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POWER_ON_WAIT: pow_q   <= cfg_wdata_i;
        CFG_BYTE_GAP:      gap_q   <= cfg_wdata_i[3:0];
        CFG_SETUP_TICKS:   setup_q <= cfg_wdata_i;
        CFG_ENABLE_HIGH:   enhi_q  <= cfg_wdata_i;
        CFG_HOLD_TICKS:    hold_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted command
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) cmd_q <= in_data_i;
  end

  // Current nibble from the table
  always_comb cur = nib_lookup(cmd_q, nib_q, gap_q, pow_q);

  // Clear the nibble counter on capture, advance on each transfer out
  always_comb begin
    nib_d = nib_q;
    if (cmd_i.capture)   nib_d = '0;
    else if (cmd_i.emit) nib_d = nib_q + 4'd1;
  end

  // Load the tick timer per phase, count down to zero
  always_comb begin
    tmr_d = tmr_q;
    if (cmd_i.tmr_load) begin
      case (cmd_i.tmr_phase)
        PH_ENHI: tmr_d = enhi_q;
        PH_HOLD: tmr_d = hold_q;
        default: tmr_d = setup_q;
      endcase
    end else if (tmr_q != 8'd0) begin
      tmr_d = tmr_q - 8'd1;
    end
  end

  // Result register: set on emit, drop on transfer
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.emit)       valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_q   <= '0;
      tmr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      nib_q   <= nib_d;
      tmr_q   <= tmr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) res_q <= cur;
  end

  assign out_valid_o    = valid_q;
  assign out_data_o     = res_q;
  assign sts_o.tmr_zero = (tmr_q == 8'd0);
  assign sts_o.last_nib = cur.last;
  assign sts_o.out_free = !valid_q || out_ready_i;

endmodule

### hw/rtl/lcdseq_ctrl.sv
// Controller: walks each nibble through setup, enable-high and hold phases,
// then hands it to the result register. Depends on lcdseq_pkg.
module lcdseq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lcdseq_pkg::dp_sts_t   sts_i,
  output lcdseq_pkg::ctrl_cmd_t cmd_o
);
  import lcdseq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_ENHI  = 3'd2;
  localparam logic [2:0] S_HOLD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.tmr_phase  = PH_SETUP;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.tmr_load = 1'b1;
          state_d        = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sts_i.tmr_zero) begin
          cmd_o.tmr_load  = 1'b1;
          cmd_o.tmr_phase = PH_ENHI;
          state_d         = S_ENHI;
        end
      end
      S_ENHI: begin
        if (sts_i.tmr_zero) begin
          cmd_o.tmr_load  = 1'b1;
          cmd_o.tmr_phase = PH_HOLD;
          state_d         = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts_i.tmr_zero) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_nib) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.tmr_load = 1'b1;
            state_d        = S_SETUP;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

### hw/rtl/char_lcd_nibble_write_sequencer_unit.sv
// Character LCD 4-bit write sequencer, top level. Each nibble passes through
// the setup, enable-high and hold phases, timed by the tick timer, and then
// waits for room in the result register before it is handed out. One command
// at a time: the block returns to idle after the last nibble before it takes
// the next. Reset clears control state and loads the register defaults.
module char_lcd_nibble_write_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lcdseq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcdseq_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lcdseq_pkg::in_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lcdseq_pkg::out_t                out_data_o
);
  import lcdseq_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lcdseq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcdseq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Capture only on an input transfer
  a_capture_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> (in_valid_i && in_ready_o))
    else $error("command captured without input transfer");

  // Never overwrite a result that is still waiting
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // Final nibble returns the block to accepting commands
  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last_nib) |=> in_ready_o)
    else $error("input not ready after final nibble");

  // No back-to-back command transfers
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second command taken while busy");

endmodule
